### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; each file that asserts includes it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/trsc_pkg.sv
// Shared types and constants for the two-rotor substitution cipher.
// No dependencies; imported by every module of the block.
package trsc_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned CHAR_W   = 8;

  // ASCII landmarks
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_GAP     = 8'h20;

  typedef enum logic [1:0] {
    ACT_LOAD_ONE = 2'd0,
    ACT_LOAD_TWO = 2'd1,
    ACT_PROCESS  = 2'd2,
    ACT_RESTART  = 2'd3
  } action_t;

  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } direction_t;

  typedef struct packed {
    action_t             action;
    logic [LETTER_W-1:0] entry_index;
    logic [LETTER_W-1:0] entry_letter;
    logic [CHAR_W-1:0]   char_in;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              was_letter;
  } result_t;

endpackage

### rtl/trsc_rotors.sv
// Rotor tables, rotor offsets and the letter mapping datapath.
// Depends on trsc_pkg; instantiated by two_rotor_substitution_cipher_top.
module trsc_rotors import trsc_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic       clk,
  input  logic       rst_n,
  input  direction_t direction,
  input  logic       step,
  input  item_t      item,
  output result_t    res
);

  localparam int unsigned IDX_W   = $clog2(ALPHABET_SIZE);
  localparam int unsigned SUM_W   = LETTER_W + 1;
  localparam int unsigned LUT_D   = 2 ** SUM_W;
  localparam logic [SUM_W-1:0] SIZE_S = SUM_W'(ALPHABET_SIZE);
  localparam logic [IDX_W-1:0] OFF_LAST  = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [LETTER_W-1:0] RUN_LAST = LETTER_W'(ALPHABET_SIZE - 2);

  logic [IDX_W-1:0] r1_fwd [ALPHABET_SIZE];
  logic [IDX_W-1:0] r1_inv [ALPHABET_SIZE];
  logic [IDX_W-1:0] r2_fwd [ALPHABET_SIZE];
  logic [IDX_W-1:0] r2_inv [ALPHABET_SIZE];

  logic [IDX_W-1:0]    off1_r, off1_nxt;
  logic [IDX_W-1:0]    off2_r, off2_nxt;
  logic [LETTER_W-1:0] run_r, run_nxt;

  logic [LETTER_W-1:0] mod_lut [LUT_D];

  logic                is_upper, is_letter, load_ok;
  logic [CHAR_W-1:0]   lc_char, p_full;
  logic [LETTER_W-1:0] p;
  logic [SUM_W-1:0]    sum;
  logic [IDX_W-1:0]    pos, x, inv, sub_off;
  logic [SUM_W-1:0]    y_wide;
  logic [IDX_W-1:0]    y;

  // Reduction modulo the alphabet size for small sums
  for (genvar g = 0; g < LUT_D; g++) begin : g_mod
    assign mod_lut[g] = LETTER_W'(g % ALPHABET_SIZE);
  end

  // Fold case and find the letter number
  always_comb begin
    is_upper  = (item.char_in >= CHAR_UPPER_A) && (item.char_in <= CHAR_UPPER_Z);
    lc_char   = is_upper ? (item.char_in + CASE_GAP) : item.char_in;
    is_letter = (lc_char >= CHAR_LOWER_A) && (lc_char <= CHAR_LOWER_Z);
    p_full    = lc_char - CHAR_LOWER_A;
    p         = p_full[LETTER_W-1:0];
  end

  // Two table lookups and the offset removal
  always_comb begin
    if (direction == DIR_ENCRYPT) begin
      sum     = SUM_W'(p) + SUM_W'(off1_r);
      pos     = mod_lut[sum][IDX_W-1:0];
      x       = r1_fwd[pos];
      inv     = r2_inv[x];
      sub_off = off2_r;
    end else begin
      sum     = SUM_W'(p) + SUM_W'(off2_r);
      pos     = mod_lut[sum][IDX_W-1:0];
      x       = r2_fwd[pos];
      inv     = r1_inv[x];
      sub_off = off1_r;
    end
    if (inv >= sub_off) begin
      y_wide = SUM_W'(inv) - SUM_W'(sub_off);
    end else begin
      y_wide = SUM_W'(inv) + SIZE_S - SUM_W'(sub_off);
    end
    y = y_wide[IDX_W-1:0];
  end

  // Result: mapped lower-case letter, or the byte passed through
  always_comb begin
    if (is_letter) begin
      res.char_out   = CHAR_LOWER_A + CHAR_W'(y);
      res.was_letter = 1'b1;
    end else begin
      res.char_out   = item.char_in;
      res.was_letter = 1'b0;
    end
  end

  // Offset and step counter next values
  always_comb begin
    off1_nxt = off1_r;
    off2_nxt = off2_r;
    run_nxt  = run_r;
    case (item.action)
      ACT_RESTART: begin
        off1_nxt = '0;
        off2_nxt = '0;
        run_nxt  = '0;
      end
      ACT_PROCESS: begin
        if (is_letter) begin
          off1_nxt = (off1_r == OFF_LAST) ? '0 : off1_r + 1'b1;
          if (run_r >= RUN_LAST) begin
            run_nxt  = '0;
            off2_nxt = (off2_r == OFF_LAST) ? '0 : off2_r + 1'b1;
          end else begin
            run_nxt = run_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off1_r <= '0;
      off2_r <= '0;
      run_r  <= '0;
    end else if (step) begin
      off1_r <= off1_nxt;
      off2_r <= off2_nxt;
      run_r  <= run_nxt;
    end
  end

  // Load a table entry together with its inverse; drop out-of-range loads
  assign load_ok = ({1'b0, item.entry_index} < SIZE_S) &&
                   ({1'b0, item.entry_letter} < SIZE_S);

  always_ff @(posedge clk) begin
    if (step && load_ok) begin
      if (item.action == ACT_LOAD_ONE) begin
        r1_fwd[item.entry_index[IDX_W-1:0]]  <= item.entry_letter[IDX_W-1:0];
        r1_inv[item.entry_letter[IDX_W-1:0]] <= item.entry_index[IDX_W-1:0];
      end
      if (item.action == ACT_LOAD_TWO) begin
        r2_fwd[item.entry_index[IDX_W-1:0]]  <= item.entry_letter[IDX_W-1:0];
        r2_inv[item.entry_letter[IDX_W-1:0]] <= item.entry_index[IDX_W-1:0];
      end
    end
  end

endmodule

### rtl/two_rotor_substitution_cipher_top.sv
// Top level of the two-rotor substitution cipher: handshakes, item and result registers.
// Depends on trsc_pkg and trsc_rotors.
//
//   channel  | ports                                                | direction
//   ---------+------------------------------------------------------+----------
//   in       | in_valid/in_ready, in_action, in_entry_index,         | sink
//            | in_entry_letter, in_char_in                           |
//   out      | out_valid/out_ready, out_char_out, out_was_letter    | source
//   cfg      | cfg_valid/cfg_ready, cfg_direction                   | sink
//
// One item per cycle unless a stalled result holds the item register.
// The combinational path is item register -> two rotor table reads -> result register.
// A stalled result holds in the result register while the item register keeps the next one.
// Synchronous active-low reset clears offsets, step counter, direction and valids;
// the rotor tables hold no reset and must be loaded before use.
module two_rotor_substitution_cipher_top import trsc_pkg::*; #(
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [LETTER_W-1:0] in_entry_index,
  input  logic [LETTER_W-1:0] in_entry_letter,
  input  logic [CHAR_W-1:0]   in_char_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_char_out,
  output logic                out_was_letter,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_direction
);

  logic       item_valid_r;
  item_t      item_r;
  logic       res_valid_r;
  result_t    res_r;
  result_t    res_calc;
  direction_t dir_r;
  logic       needs_out, item_go;

  // Configuration register: always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENCRYPT;
    end else if (cfg_valid) begin
      dir_r <= direction_t'(cfg_direction);
    end
  end

  // Advance the held item unless its result has nowhere to go
  assign needs_out = (item_r.action == ACT_PROCESS);
  assign item_go   = item_valid_r && (!needs_out || !res_valid_r || out_ready);
  assign in_ready  = !item_valid_r || item_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.action       <= action_t'(in_action);
      item_r.entry_index  <= in_entry_index;
      item_r.entry_letter <= in_entry_letter;
      item_r.char_in      <= in_char_in;
    end
  end

  trsc_rotors #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_rotors (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (dir_r),
    .step      (item_go),
    .item      (item_r),
    .res       (res_calc)
  );

  // Result register: load on a processed item, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (item_go && needs_out) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go && needs_out) begin
      res_r <= res_calc;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_char_out   = res_r.char_out;
  assign out_was_letter = res_r.was_letter;

endmodule

### rtl/trsc_checker.sv
// Port-level checks for the two-rotor substitution cipher, bound to the top level.
// Depends on trsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trsc_checker import trsc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CHAR_W-1:0]   out_char_out,
  input logic                out_was_letter
);

  // Hold a stalled result
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_char_out) && $stable(out_was_letter), "stalled result changed")

  // A passed-through byte is never a letter
  `ASSERT_CLK(a_pass_not_letter, out_valid && !out_was_letter |-> !((out_char_out >= CHAR_LOWER_A && out_char_out <= CHAR_LOWER_Z) || (out_char_out >= CHAR_UPPER_A && out_char_out <= CHAR_UPPER_Z)), "letter passed through unmapped")

  // A fresh result follows an earlier input transfer through the item register
  `ASSERT_CLK(a_out_from_in, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without input transfer")

  // Reset empties the result register
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind two_rotor_substitution_cipher_top trsc_checker u_trsc_checker (.*);

### tb/rotor_shadow_pkg.sv
// Shadow of the two-rotor cipher: rotor tables, offsets, direction and awaited results.
// Depends on trsc_pkg; imported by the cipher testbench top.
package rotor_shadow_pkg;
  import trsc_pkg::*;

  localparam int unsigned ALPHA        = 26;
  localparam int unsigned REPORT_LIMIT = 10;

  function automatic bit is_letter(logic [CHAR_W-1:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
  endfunction

  class rotor_shadow;
    logic [LETTER_W-1:0] one_fwd [ALPHA];
    logic [LETTER_W-1:0] one_inv [ALPHA];
    logic [LETTER_W-1:0] two_fwd [ALPHA];
    logic [LETTER_W-1:0] two_inv [ALPHA];
    int unsigned one_pos    = 0;
    int unsigned two_pos    = 0;
    int unsigned since_step = 0;
    direction_t  dir        = DIR_ENCRYPT;
    result_t     awaited_q [$];

    // run statistics
    int unsigned failures  = 0;
    int unsigned checked   = 0;
    int unsigned letters   = 0;
    int unsigned others    = 0;
    int unsigned loads     = 0;
    int unsigned restarts  = 0;
    int unsigned two_steps = 0;
    int unsigned decrypted = 0;

    function void set_direction(direction_t d);
      dir = d;
    endfunction

    // Apply one accepted item and queue the character it should produce, if any
    function void absorb_item(action_t act, logic [LETTER_W-1:0] idx,
                              logic [LETTER_W-1:0] ltr, logic [CHAR_W-1:0] ch);
      int unsigned p, x, y;
      result_t r;
      case (act)
        ACT_LOAD_ONE: begin
          if (idx < ALPHA && ltr < ALPHA) begin
            one_fwd[idx] = ltr;
            one_inv[ltr] = idx;
            loads++;
          end
        end
        ACT_LOAD_TWO: begin
          if (idx < ALPHA && ltr < ALPHA) begin
            two_fwd[idx] = ltr;
            two_inv[ltr] = idx;
            loads++;
          end
        end
        ACT_RESTART: begin
          one_pos    = 0;
          two_pos    = 0;
          since_step = 0;
          restarts++;
        end
        default: begin
          if (!is_letter(ch)) begin
            // non-letters pass straight through and leave the rotors alone
            r.char_out   = ch;
            r.was_letter = 1'b0;
            others++;
          end else begin
            p = (ch >= CHAR_LOWER_A) ? ch - CHAR_LOWER_A : ch - CHAR_UPPER_A;
            if (dir == DIR_ENCRYPT) begin
              x = one_fwd[(p + one_pos) % ALPHA];
              y = (two_inv[x % ALPHA] + ALPHA - two_pos) % ALPHA;
            end else begin
              x = two_fwd[(p + two_pos) % ALPHA];
              y = (one_inv[x % ALPHA] + ALPHA - one_pos) % ALPHA;
              decrypted++;
            end
            r.char_out   = CHAR_W'(CHAR_LOWER_A + y);
            r.was_letter = 1'b1;
            letters++;
            // rotor one steps every letter, rotor two once per ALPHA-1 letters
            one_pos = (one_pos + 1) % ALPHA;
            since_step++;
            if (since_step >= ALPHA - 1) begin
              since_step = 0;
              two_pos    = (two_pos + 1) % ALPHA;
              two_steps++;
            end
          end
          awaited_q.push_back(r);
        end
      endcase
    endfunction

    // Match one delivered character against the oldest awaited one
    function void check_result(logic [CHAR_W-1:0] char_out, logic was_letter);
      result_t want;
      checked++;
      if (awaited_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected output: char %h was_letter %b", char_out, was_letter);
        return;
      end
      want = awaited_q.pop_front();
      if (char_out !== want.char_out || was_letter !== want.was_letter) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch at output %0d: expected char %h was_letter %b, got char %h was_letter %b",
                   checked, want.char_out, want.was_letter, char_out, was_letter);
      end
    endfunction
  endclass

endpackage

### tb/two_rotor_substitution_cipher_top_tb.sv
// Testbench top for the two-rotor substitution cipher: drives keys, text and direction.
// Depends on trsc_pkg, rotor_shadow_pkg and two_rotor_substitution_cipher_top.
module two_rotor_substitution_cipher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trsc_pkg::*;
  import rotor_shadow_pkg::*;

  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD     = 48;
  localparam int unsigned LIMIT_CYCLES  = 400_000;
  localparam int unsigned PHASES        = 5;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [1:0]          in_action       = ACT_PROCESS;
  logic [LETTER_W-1:0] in_entry_index  = '0;
  logic [LETTER_W-1:0] in_entry_letter = '0;
  logic [CHAR_W-1:0]   in_char_in      = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic [CHAR_W-1:0]   out_char_out;
  logic                out_was_letter;
  logic                cfg_valid       = 1'b0;
  logic                cfg_ready;
  logic                cfg_direction   = DIR_ENCRYPT;

  // stimulus controls seen by the receiver
  logic        idling        = 1'b1;
  logic        long_hold_req = 1'b0;
  bit          hold_taken    = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned burst_left    = 0;

  rotor_shadow shadow;

  two_rotor_substitution_cipher_top #(
    .ALPHABET_SIZE(ALPHA)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_entry_letter(in_entry_letter),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_out   (out_char_out),
    .out_was_letter (out_was_letter),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_direction  (cfg_direction)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: one long hold on request, otherwise short random stall bursts while idling is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_ready <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check every output transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      shadow.check_result(out_char_out, out_was_letter);
  end

  function automatic logic [LETTER_W-1:0] any5();
    return LETTER_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [CHAR_W-1:0] any8();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_letter();
    logic [CHAR_W-1:0] base;
    base = ($urandom_range(0, 1) != 0) ? CHAR_UPPER_A : CHAR_LOWER_A;
    return CHAR_W'(base + $urandom_range(0, ALPHA - 1));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_other();
    logic [CHAR_W-1:0] c;
    do c = any8(); while (is_letter(c));
    return c;
  endfunction

  // Offer one item, hold it until the transfer, then note it
  task automatic send_item(action_t act, logic [LETTER_W-1:0] idx,
                           logic [LETTER_W-1:0] ltr, logic [CHAR_W-1:0] ch);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_entry_index  <= idx;
    in_entry_letter <= ltr;
    in_char_in      <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.absorb_item(act, idx, ltr, ch);
  endtask

  task automatic write_direction(direction_t d);
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow.set_direction(d);
    cfg_valid <= 1'b0;
  endtask

  // Load a fresh random permutation into one rotor, in shuffled index order
  task automatic load_rotor(action_t which);
    logic [LETTER_W-1:0] perm [ALPHA];
    logic [LETTER_W-1:0] order [ALPHA];
    logic [LETTER_W-1:0] t;
    int unsigned j;
    for (int i = 0; i < ALPHA; i++) begin
      perm[i]  = LETTER_W'(i);
      order[i] = LETTER_W'(i);
    end
    for (int i = ALPHA - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];  perm[i]  = perm[j];  perm[j]  = t;
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    for (int i = 0; i < ALPHA; i++)
      send_item(which, order[i], perm[order[i]], any8());
  endtask

  // Drop valid and wait until every awaited character is back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [CHAR_W-1:0] borders [6];
    logic [CHAR_W-1:0] letters [6];
    borders = '{8'h00, 8'hff, CHAR_UPPER_A - 8'd1, CHAR_UPPER_Z + 8'd1,
                CHAR_LOWER_A - 8'd1, CHAR_LOWER_Z + 8'd1};
    letters = '{CHAR_UPPER_A, CHAR_UPPER_Z, CHAR_LOWER_A, CHAR_LOWER_Z,
                CHAR_UPPER_A + 8'd12, CHAR_LOWER_A + 8'd13};
    // bytes at the ends of the byte range and just outside the letter ranges, before any key exists
    foreach (borders[i]) send_item(ACT_PROCESS, any5(), any5(), borders[i]);
    load_rotor(ACT_LOAD_ONE);
    load_rotor(ACT_LOAD_TWO);
    // loads with index or letter past the alphabet are dropped
    send_item(ACT_LOAD_ONE, LETTER_W'(ALPHA), 5'd3, any8());
    send_item(ACT_LOAD_TWO, 5'd31, 5'd0, any8());
    send_item(ACT_LOAD_ONE, 5'd0, 5'd31, any8());
    send_item(ACT_LOAD_TWO, LETTER_W'(ALPHA - 1), LETTER_W'(ALPHA), any8());
    foreach (letters[i]) send_item(ACT_PROCESS, any5(), any5(), letters[i]);
    send_item(ACT_RESTART, any5(), any5(), any8());
    send_item(ACT_PROCESS, 5'd31, 5'd31, CHAR_LOWER_A);
  endtask

  // Mostly letter runs, with stray bytes, key edits, rekeys and restarts mixed in
  task automatic run_text(int unsigned count, int unsigned restart_pm);
    int unsigned done = 0;
    int unsigned pick;
    action_t rotor;
    logic [LETTER_W-1:0] idx, ltr;
    while (done < count) begin
      pick  = $urandom_range(0, 99);
      rotor = ($urandom_range(0, 1) != 0) ? ACT_LOAD_TWO : ACT_LOAD_ONE;
      if ($urandom_range(0, 999) < restart_pm) begin
        send_item(ACT_RESTART, any5(), any5(), any8());
        done++;
      end else if ($urandom_range(0, 399) == 0) begin
        load_rotor(rotor);
        done += ALPHA;
      end else if (pick < 3) begin
        send_item(rotor, LETTER_W'($urandom_range(0, ALPHA - 1)),
                  LETTER_W'($urandom_range(0, ALPHA - 1)), any8());
        done++;
      end else if (pick < 6) begin
        // out-of-range load: ignored by the block, so not counted
        if ($urandom_range(0, 1) != 0) begin
          idx = LETTER_W'($urandom_range(ALPHA, 31));
          ltr = any5();
        end else begin
          idx = any5();
          ltr = LETTER_W'($urandom_range(ALPHA, 31));
        end
        send_item(rotor, idx, ltr, any8());
      end else if (pick < 14) begin
        send_item(ACT_PROCESS, any5(), any5(), pick_other());
        done++;
      end else begin
        send_item(ACT_PROCESS, any5(), any5(), pick_letter());
        done++;
      end
    end
  endtask

  initial begin
    direction_t  dir_plan     [PHASES] = '{DIR_DECRYPT, DIR_ENCRYPT, DIR_DECRYPT,
                                           DIR_ENCRYPT, DIR_DECRYPT};
    int unsigned len_plan     [PHASES] = '{320, 300, 700, 300, 280};
    int unsigned restart_plan [PHASES] = '{5, 5, 0, 5, 5};
    shadow = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    write_direction(DIR_ENCRYPT);
    run_directed();
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_direction(dir_plan[ph]);
      // last phase runs flat out on both sides
      idling <= (ph != PHASES - 1);
      // stall the output early in the first phase while text keeps coming
      if (ph == 0)
        long_hold_req <= 1'b1;
      run_text(len_plan[ph], restart_plan[ph]);
      drain();
    end

    $display("covered %0d letters (%0d decrypted, %0d rotor-two steps), %0d other bytes,",
             shadow.letters, shadow.decrypted, shadow.two_steps, shadow.others);
    $display("  %0d table loads, %0d restarts; %0d outputs checked, %0d failures",
             shadow.loads, shadow.restarts, shadow.checked, shadow.failures);
    if (shadow.failures == 0 && shadow.awaited_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("watchdog expired with %0d outputs outstanding", shadow.awaited_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
